### sv/xbpc_pkg.sv
// Package for the XML byte preflight checker.
// Holds the status codes, markup phase codes and the checker state type.
// No dependencies.
package xbpc_pkg;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CONTROL = 3'd1;
	localparam logic [2:0] ST_TOKEN   = 3'd2;
	localparam logic [2:0] ST_MARKUP  = 3'd3;
	localparam logic [2:0] ST_UTF8    = 3'd4;

	localparam logic [1:0] MK_IDLE      = 2'd0;
	localparam logic [1:0] MK_LT        = 2'd1;
	localparam logic [1:0] MK_LT_BANG   = 2'd2;
	localparam logic [1:0] MK_LT_BANG_D = 2'd3;

	localparam logic [15:0] SPAN_LIMIT_RESET = 16'd8192;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2d;

	localparam logic [20:0] CP_MIN_2 = 21'h80;
	localparam logic [20:0] CP_MIN_3 = 21'd2048;
	localparam logic [20:0] CP_MIN_4 = 21'd65536;
	localparam logic [20:0] CP_MAX   = 21'h10ffff;
	localparam logic [20:0] SURR_LO  = 21'hd800;
	localparam logic [20:0] SURR_HI  = 21'hdfff;

	typedef struct packed {
		logic [15:0] span_count;
		logic [1:0]  markup_phase;
		logic [1:0]  utf8_remaining;
		logic [1:0]  utf8_length;
		logic [20:0] code_point;
		logic [2:0]  error_code;
	} xbpc_state_t;

	localparam xbpc_state_t STATE_RESET = '{
		span_count:     16'd0,
		markup_phase:   MK_IDLE,
		utf8_remaining: 2'd0,
		utf8_length:    2'd0,
		code_point:     21'd0,
		error_code:     ST_OK
	};

endpackage

### sv/xbpc_if.sv
// Stream interfaces for the XML byte preflight checker.
// The byte channel and the result channel; depends on nothing.
interface xbpc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface xbpc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       final_res;

	modport source (output valid, output status, output final_res, input ready);
	modport sink (input valid, input status, input final_res, output ready);
endinterface

### sv/xbpc_step.sv
// Per-byte next-state logic of the XML byte preflight checker.
// Purely combinational; depends on xbpc_pkg.
module xbpc_step (
	input  xbpc_pkg::xbpc_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic                  is_last,
	input  logic [15:0]           span_limit,
	output xbpc_pkg::xbpc_state_t nxt,
	output logic [2:0]            status
);
	import xbpc_pkg::*;

	always_comb begin
		xbpc_state_t s;
		logic        held;
		logic        done;
		logic [16:0] span_next;
		logic [2:0]  lead_len;
		logic [20:0] cp;
		logic [20:0] cp_min;

		s = cur;
		held = 1'b0;
		done = 1'b0;
		span_next = {1'b0, cur.span_count} + 17'd1;
		lead_len = 3'd0;
		cp = 21'd0;
		cp_min = CP_MIN_4;

		if (cur.error_code == ST_OK) begin
			if (cur.utf8_remaining != 2'd0) begin
				if (data_byte[7:6] != 2'b10) begin
					s.error_code = ST_UTF8;
				end else begin
					cp = {cur.code_point[14:0], data_byte[5:0]};
					s.code_point = cp;
					s.utf8_remaining = cur.utf8_remaining - 2'd1;
					if (cur.utf8_remaining == 2'd1) begin
						case (cur.utf8_length)
							2'd1:    cp_min = CP_MIN_2;
							2'd2:    cp_min = CP_MIN_3;
							default: cp_min = CP_MIN_4;
						endcase
						if (cp < cp_min || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
							s.error_code = ST_UTF8;
						end
					end
				end
			end else begin
				if (cur.markup_phase == MK_LT_BANG || cur.markup_phase == MK_LT_BANG_D) begin
					if (data_byte != CH_DASH) begin
						s.error_code = ST_MARKUP;
						done = 1'b1;
					end else if (cur.markup_phase == MK_LT_BANG) begin
						s.markup_phase = MK_LT_BANG_D;
						held = 1'b1;
					end else begin
						s.markup_phase = MK_IDLE;
					end
				end else if (cur.markup_phase == MK_LT) begin
					if (data_byte == CH_BANG) begin
						s.markup_phase = MK_LT_BANG;
						held = 1'b1;
					end else begin
						s.markup_phase = MK_IDLE;
					end
				end

				if (!done && data_byte < 8'h20 && data_byte != CH_TAB &&
						data_byte != CH_LF && data_byte != CH_CR) begin
					s.error_code = ST_CONTROL;
					done = 1'b1;
				end

				if (!done) begin
					if (data_byte == CH_LT || data_byte == CH_GT) begin
						s.span_count = 16'd0;
					end else if (!held && span_next > {1'b0, span_limit}) begin
						s.error_code = ST_TOKEN;
						done = 1'b1;
					end else begin
						s.span_count = span_next[15:0];
					end
				end

				if (!done) begin
					if (data_byte == CH_LT) begin
						s.markup_phase = MK_LT;
					end
					if (data_byte[7]) begin
						if (data_byte >= 8'hf8) begin
							lead_len = 3'd0;
						end else if (data_byte >= 8'hf0) begin
							lead_len = 3'd4;
						end else if (data_byte >= 8'he0) begin
							lead_len = 3'd3;
						end else if (data_byte >= 8'hc2) begin
							lead_len = 3'd2;
						end else begin
							lead_len = 3'd0;
						end
						case (lead_len)
							3'd2:    s.code_point = {16'd0, data_byte[4:0]};
							3'd3:    s.code_point = {17'd0, data_byte[3:0]};
							3'd4:    s.code_point = {18'd0, data_byte[2:0]};
							default: s.error_code = ST_UTF8;
						endcase
						if (lead_len != 3'd0) begin
							s.utf8_length = 2'(lead_len - 3'd1);
							s.utf8_remaining = 2'(lead_len - 3'd1);
						end
					end
				end
			end
		end

		if (is_last && s.error_code == ST_OK) begin
			if (s.utf8_remaining != 2'd0) begin
				s.error_code = ST_UTF8;
			end else if (s.markup_phase == MK_LT_BANG || s.markup_phase == MK_LT_BANG_D) begin
				s.error_code = ST_MARKUP;
			end
		end

		status = s.error_code;
		nxt = is_last ? STATE_RESET : s;
	end

endmodule

### sv/xml_byte_preflight_checker_core.sv
// Top level of the XML byte preflight checker.
// Input register, per-byte check logic and result register with an APB register port.
// Depends on xbpc_pkg, xbpc_if.sv and xbpc_step.
//
// The checker takes one document byte per cycle and returns one status per byte: the
// byte is held in the input register, then its status is written to the result
// register. The state update for a byte is combinational logic, so bytes stream
// back to back at one per cycle as long as the result side keeps taking results.
// The status is sticky from the first error until the byte marked last, whose result
// carries final_res and after which the document state is cleared. The span limit
// register sits at byte address 0 and should only be written while no transaction is
// in flight.
module xml_byte_preflight_checker_core (
	input  logic                 clk,
	input  logic                 arst_n,
	xbpc_byte_if.sink            byte_in,
	xbpc_result_if.source        result_out,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import xbpc_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        final_q;
	logic [15:0] span_limit_q;
	xbpc_state_t state_q;
	xbpc_state_t state_nxt;
	logic [2:0]  status_nxt;
	logic        advance;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, span_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_limit_q <= SPAN_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			span_limit_q <= pwdata[15:0];
		end
	end

	assign advance = valid_s1 && (!out_valid_q || result_out.ready);
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.is_last;
		end
	end

	xbpc_step u_step (
		.cur        (state_q),
		.data_byte  (data_s1),
		.is_last    (last_s1),
		.span_limit (span_limit_q),
		.nxt        (state_nxt),
		.status     (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_nxt;
			final_q <= last_s1;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.status = status_q;
	assign result_out.final_res = final_q;

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q == STATE_RESET)
		else $error("State was not cleared after the last byte of a document.");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && state_q.error_code != ST_OK |=>
		state_q.error_code == $past(state_q.error_code))
		else $error("A recorded error changed before the end of the document.");

	a_status_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 |=> status_q == state_q.error_code)
		else $error("The reported status differs from the recorded error.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> status_q <= ST_UTF8)
		else $error("Status code out of range.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_out.ready |-> !advance)
		else $error("A pending result was overwritten.");
`endif

endmodule

### verif/tb_xml_byte_preflight_checker_core.sv
// Testbench for xml_byte_preflight_checker_core: directed and random documents
// checked against a cycle-free predictor of the byte checks, with APB span limit writes.
// Depends on xbpc_pkg, the stream interfaces in xbpc_if.sv and the checker RTL.
module tb_xml_byte_preflight_checker_core;
	import xbpc_pkg::*;

	localparam int         CYCLE_LIMIT     = 200000;
	localparam int         PIPE_LATENCY    = 2;
	localparam logic [2:0] SPAN_LIMIT_ADDR = 3'd0;

	typedef struct packed {
		logic [2:0] status;
		logic       final_res;
	} byte_status_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = SPAN_LIMIT_ADDR;
	logic [31:0] pwdata  = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	xbpc_byte_if   byte_ch ();
	xbpc_result_if res_ch ();

	xml_byte_preflight_checker_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.result_out (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Predictor state, mirroring one document in progress.
	logic [15:0] span_limit_q = SPAN_LIMIT_RESET;
	logic [15:0] span_cnt     = 16'd0;
	logic [1:0]  mk_phase     = MK_IDLE;
	logic [1:0]  seq_left     = 2'd0;
	logic [1:0]  seq_len      = 2'd0;
	logic [20:0] cp_acc       = 21'd0;
	logic [2:0]  doc_status   = ST_OK;

	byte_status_t byte_status_q[$];
	logic [7:0]   doc_bytes[$];

	int scanned_bytes  = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int sink_hold_left = 0;
	bit source_idle_en = 1'b1;
	bit sink_idle_en   = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic byte_status_t scan_byte_status(input logic [7:0] c, input logic last);
		logic [16:0]  next_span;
		logic [20:0]  min_cp;
		logic         held;
		byte_status_t res;
		held = 1'b0;
		if (doc_status == ST_OK) begin
			if (seq_left != 2'd0) begin
				if (c[7:6] != 2'b10) begin
					doc_status = ST_UTF8;
				end else begin
					cp_acc   = {cp_acc[14:0], c[5:0]};
					seq_left = seq_left - 2'd1;
					if (seq_left == 2'd0) begin
						min_cp = (seq_len == 2'd1) ? CP_MIN_2 :
							(seq_len == 2'd2) ? CP_MIN_3 : CP_MIN_4;
						if (cp_acc < min_cp || cp_acc > CP_MAX ||
							(cp_acc >= SURR_LO && cp_acc <= SURR_HI))
							doc_status = ST_UTF8;
					end
				end
			end else begin
				if (mk_phase == MK_LT_BANG || mk_phase == MK_LT_BANG_D) begin
					if (c != CH_DASH) begin
						doc_status = ST_MARKUP;
					end else if (mk_phase == MK_LT_BANG) begin
						mk_phase = MK_LT_BANG_D;
						held     = 1'b1;
					end else begin
						mk_phase = MK_IDLE;
					end
				end else if (mk_phase == MK_LT) begin
					if (c == CH_BANG) begin
						mk_phase = MK_LT_BANG;
						held     = 1'b1;
					end else begin
						mk_phase = MK_IDLE;
					end
				end
				if (doc_status == ST_OK && c < 8'h20 && c != CH_TAB && c != CH_LF && c != CH_CR)
					doc_status = ST_CONTROL;
				if (doc_status == ST_OK) begin
					if (c == CH_LT || c == CH_GT) begin
						span_cnt = 16'd0;
					end else begin
						next_span = {1'b0, span_cnt} + 17'd1;
						if (!held && next_span > {1'b0, span_limit_q})
							doc_status = ST_TOKEN;
						else
							span_cnt = next_span[15:0];
					end
				end
				if (doc_status == ST_OK && c == CH_LT)
					mk_phase = MK_LT;
				if (doc_status == ST_OK && c[7]) begin
					if (c >= 8'hf8 || c < 8'hc2) begin
						doc_status = ST_UTF8;
					end else begin
						if (c >= 8'hf0) begin
							cp_acc  = {18'd0, c[2:0]};
							seq_len = 2'd3;
						end else if (c >= 8'he0) begin
							cp_acc  = {17'd0, c[3:0]};
							seq_len = 2'd2;
						end else begin
							cp_acc  = {16'd0, c[4:0]};
							seq_len = 2'd1;
						end
						seq_left = seq_len;
					end
				end
			end
		end
		if (last && doc_status == ST_OK) begin
			if (seq_left != 2'd0)
				doc_status = ST_UTF8;
			else if (mk_phase == MK_LT_BANG || mk_phase == MK_LT_BANG_D)
				doc_status = ST_MARKUP;
		end
		res.status    = doc_status;
		res.final_res = last;
		if (last) begin
			span_cnt   = 16'd0;
			mk_phase   = MK_IDLE;
			seq_left   = 2'd0;
			seq_len    = 2'd0;
			cp_acc     = 21'd0;
			doc_status = ST_OK;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (sink_hold_left > 0) begin
			res_ch.ready <= 1'b0;
			sink_hold_left--;
		end else if (sink_idle_en) begin
			res_ch.ready <= ($urandom_range(99) >= 23);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		byte_status_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (byte_status_q.size() == 0) begin
				$error("unexpected transaction: status %0d, final_res %0b",
					res_ch.status, res_ch.final_res);
				mismatch_count++;
			end else begin
				want = byte_status_q.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					mismatch_count++;
				end
				if (res_ch.final_res !== want.final_res) begin
					$error("final_res: expected %0b, got %0b", want.final_res, res_ch.final_res);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic last);
		if (source_idle_en && $urandom_range(99) < 23) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 23);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= c;
		byte_ch.is_last   <= last;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		scanned_bytes++;
		byte_status_q.insert(byte_status_q.size(), scan_byte_status(c, last));
	endtask

	task automatic send_document();
		for (int i = 0; i < doc_bytes.size(); i++)
			send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (byte_status_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_span_limit(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SPAN_LIMIT_ADDR;
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		span_limit_q = value;
	endtask

	function automatic void append_byte(input logic [7:0] b);
		doc_bytes.insert(doc_bytes.size(), b);
	endfunction

	function automatic void push_utf8(input logic [20:0] cp, input int n);
		case (n)
			1: append_byte({1'b0, cp[6:0]});
			2: begin
				append_byte({3'b110, cp[10:6]});
				append_byte({2'b10, cp[5:0]});
			end
			3: begin
				append_byte({4'b1110, cp[15:12]});
				append_byte({2'b10, cp[11:6]});
				append_byte({2'b10, cp[5:0]});
			end
			default: begin
				append_byte({5'b11110, cp[20:18]});
				append_byte({2'b10, cp[17:12]});
				append_byte({2'b10, cp[11:6]});
				append_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic void push_text_char();
		logic [20:0] cp;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: append_byte(8'($urandom_range(8'h7e, 8'h20)));
			5: case ($urandom_range(2))
				0: append_byte(CH_TAB);
				1: append_byte(CH_LF);
				default: append_byte(CH_CR);
			endcase
			6: push_utf8(21'($urandom_range(12'h7ff, 8'h80)), 2);
			7: begin
				cp = 21'($urandom_range(16'hffff, 12'h800));
				if (cp >= SURR_LO && cp <= SURR_HI)
					cp = cp - 21'h1000;
				push_utf8(cp, 3);
			end
			8: push_utf8(21'($urandom_range(21'h10ffff, 21'h10000)), 4);
			default: case ($urandom_range(7))
				0: push_utf8(CP_MIN_2, 2);
				1: push_utf8(CP_MIN_3 - 21'd1, 2);
				2: push_utf8(CP_MIN_3, 3);
				3: push_utf8(SURR_LO - 21'd1, 3);
				4: push_utf8(SURR_HI + 21'd1, 3);
				5: push_utf8(CP_MIN_4 - 21'd1, 3);
				6: push_utf8(CP_MIN_4, 4);
				default: push_utf8(CP_MAX, 4);
			endcase
		endcase
	endfunction

	function automatic void push_fault();
		case ($urandom_range(8))
			0: append_byte(8'($urandom_range(8'h1f)));
			1: append_byte(8'h00);
			2: append_byte(8'($urandom_range(8'hc1, 8'h80)));
			3: append_byte(8'($urandom_range(8'hff, 8'hf8)));
			4: case ($urandom_range(2))
				0: push_utf8(21'($urandom_range(8'h7f)), 2);
				1: push_utf8(21'($urandom_range(12'h7ff)), 3);
				default: push_utf8(21'($urandom_range(16'hffff)), 4);
			endcase
			5: push_utf8(21'($urandom_range(SURR_HI, SURR_LO)), 3);
			6: push_utf8(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
			7: begin
				append_byte(8'($urandom_range(8'hf4, 8'hc2)));
				append_byte($urandom_range(1) ? 8'($urandom_range(8'h7f)) :
					8'($urandom_range(8'hff, 8'hc0)));
			end
			default: begin
				append_byte(CH_LT);
				append_byte(CH_BANG);
				if ($urandom_range(1))
					append_byte(CH_DASH);
				append_byte(8'($urandom_range(8'h2c)));
			end
		endcase
	endfunction

	function automatic void build_document();
		int style;
		doc_bytes.delete();
		style = $urandom_range(99);
		if (style < 10) begin
			repeat ($urandom_range(6, 1)) append_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(12, 1)) begin
				case ($urandom_range(9))
					0: begin
						append_byte(CH_LT);
						repeat ($urandom_range(6, 1))
							append_byte(8'($urandom_range(8'h7a, 8'h61)));
						append_byte(CH_GT);
					end
					1: begin
						append_byte(CH_LT);
						append_byte(CH_BANG);
						append_byte(CH_DASH);
						append_byte(CH_DASH);
						repeat ($urandom_range(4)) push_text_char();
						append_byte(CH_DASH);
						append_byte(CH_DASH);
						append_byte(CH_GT);
					end
					default: push_text_char();
				endcase
			end
			if (style < 30) begin
				push_fault();
				repeat ($urandom_range(2)) push_text_char();
			end else if (style < 40) begin
				case ($urandom_range(4))
					0: append_byte(8'($urandom_range(8'hf7, 8'hc2)));
					1: begin
						append_byte(8'($urandom_range(8'hf7, 8'he0)));
						append_byte(8'($urandom_range(8'hbf, 8'h80)));
					end
					2: begin
						append_byte(CH_LT);
						append_byte(CH_BANG);
					end
					3: begin
						append_byte(CH_LT);
						append_byte(CH_BANG);
						append_byte(CH_DASH);
					end
					default: append_byte(CH_LT);
				endcase
			end
		end
	endfunction

	task automatic test_register_reset();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= SPAN_LIMIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[15:0] !== SPAN_LIMIT_RESET) begin
			$error("span_limit: expected %0d, got %0d", SPAN_LIMIT_RESET, prdata[15:0]);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_control_bytes();
		doc_bytes = '{CH_TAB, CH_LF, CH_CR, 8'h00, 8'h41};
		send_document();
		doc_bytes = '{8'h1f};
		send_document();
	endtask

	task automatic test_markup_openers();
		doc_bytes = '{CH_LT, CH_BANG, CH_DASH, CH_DASH};
		send_document();
		doc_bytes = '{CH_LT, CH_BANG, CH_DASH, 8'h41};
		send_document();
		doc_bytes = '{CH_LT, CH_BANG};
		send_document();
		doc_bytes = '{CH_LT};
		send_document();
	endtask

	task automatic test_utf8_forms();
		doc_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_document();
		doc_bytes = '{8'hed, 8'ha0, 8'h80};
		send_document();
		doc_bytes = '{8'he2, 8'h41};
		send_document();
		doc_bytes = '{8'hc1};
		send_document();
		doc_bytes = '{8'hff};
		send_document();
		doc_bytes = '{8'he0, 8'ha0};
		send_document();
	endtask

	task automatic test_span_limit();
		wait_drained();
		write_span_limit(16'd1);
		doc_bytes = '{8'h61, 8'h62};
		send_document();
		doc_bytes = '{CH_LT, CH_BANG, CH_DASH, CH_DASH};
		send_document();
		wait_drained();
		write_span_limit(16'd2);
		doc_bytes = '{CH_LT, CH_BANG, CH_DASH, 8'h78};
		send_document();
	endtask

	task automatic test_random_documents(input logic [15:0] limit, input int target);
		int goal;
		wait_drained();
		write_span_limit(limit);
		goal = scanned_bytes + target;
		while (scanned_bytes < goal) begin
			build_document();
			send_document();
		end
	endtask

	task automatic test_backpressure();
		source_idle_en = 1'b0;
		sink_hold_left = 80;
		doc_bytes.delete();
		repeat (40) push_text_char();
		send_document();
		source_idle_en = 1'b1;
	endtask

	task automatic test_full_rate();
		source_idle_en = 1'b0;
		sink_idle_en   = 1'b0;
		test_random_documents(16'd40, 100);
		source_idle_en = 1'b1;
		sink_idle_en   = 1'b1;
	endtask

	initial begin
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = 8'd0;
		byte_ch.is_last   = 1'b0;
		res_ch.ready      = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_register_reset();
		test_control_bytes();
		test_markup_openers();
		test_utf8_forms();
		test_span_limit();
		test_random_documents(SPAN_LIMIT_RESET, 200);
		test_backpressure();
		test_random_documents(16'hffff, 100);
		test_random_documents(16'($urandom_range(16, 4)), 150);
		test_random_documents(16'd1, 30);
		test_full_rate();
		wait_drained();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
sv/xbpc_pkg.sv
sv/xbpc_if.sv
sv/xbpc_step.sv
sv/xml_byte_preflight_checker_core.sv
verif/tb_xml_byte_preflight_checker_core.sv
